@@ rtl/paged_virtual_memory_access_macros.svh @@
// Assertion macros shared by the checkers of the paged memory access block.
`ifndef PAGED_VIRTUAL_MEMORY_ACCESS_MACROS_SVH
`define PAGED_VIRTUAL_MEMORY_ACCESS_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define PVMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pvma assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define PVMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pvma assertion failed");

`endif

@@ rtl/pvma_pkg.sv @@
// Types and constants of the paged virtual memory access block.
`timescale 1ns / 1ps

package pvma_pkg;

	localparam int MEM_ADDR_BITS_DEF = 16;
	localparam int PAGE_BITS         = 12;
	localparam int DIR_SHIFT         = 22;
	localparam int CFG_DATA_BITS     = 20;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	localparam logic CFG_PAGING_ENABLE   = 1'b0;
	localparam logic CFG_DIRECTORY_FRAME = 1'b1;

	localparam logic LVL_DIR = 1'b0;
	localparam logic LVL_TAB = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK_ADDR,
		ST_ENTRY,
		ST_ENTRY_WAIT,
		ST_WALK_NEXT,
		ST_CHECK,
		ST_DATA,
		ST_DATA_WAIT,
		ST_DONE
	} state_t;

endpackage

@@ rtl/paged_virtual_memory_access.sv @@
// Top level of the paged virtual memory access block: page walk and byte memory.
`timescale 1ns / 1ps

// From accepting start to the done strobe: paging off goes straight to the range check,
//   the data bytes and done; paging on first walks directory and table, twice for a split access.
//   An entry beyond memory is not fetched and reads as zero.
// Throughput: one word at a time; start is taken again the cycle after done.
//   The single-port byte memory sets this: one byte per cycle, entry or data.
// Reset clears the sequencer state and the configuration; memory content is undefined.
module paged_virtual_memory_access #(
	parameter int MEM_ADDR_BITS = pvma_pkg::MEM_ADDR_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               config_write,
	input  logic                               config_index,
	input  logic [pvma_pkg::CFG_DATA_BITS-1:0] config_data,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic [31:0]                        virtual_address,
	input  logic [2:0]                         byte_count,
	input  logic [31:0]                        write_data,
	// result side
	output logic                               done,
	output logic [31:0]                        read_data,
	output logic [31:0]                        physical_address,
	output logic                               page_crossed,
	output logic                               range_error
);

	localparam int unsigned MemBytes = 1 << MEM_ADDR_BITS;
	// one past the last byte, as a 33-bit bound for the range checks
	localparam logic [32:0] MemEnd = 33'd1 << MEM_ADDR_BITS;

	pvma_pkg::state_t state_q, state_d;

	// configuration registers
	logic        paging_enable_q;
	logic [19:0] directory_frame_q;

	// access registers
	logic        mode_q;
	logic [31:0] va_q;
	logic [31:0] va2_q;      // virtual address of the upper part
	logic [31:0] wdata_q;
	logic [2:0]  len1_q;
	logic [2:0]  len2_q;
	logic        crossed_q;
	logic [31:0] pa1_q;
	logic [31:0] pa2_q;
	logic        range_q;

	// sequencer registers
	logic        part_q;     // 0: lower part, 1: upper part
	logic        lvl_q;      // directory or table level of the walk
	logic [31:0] base_q;     // byte address of the current entry or data part
	logic [1:0]  bcnt_q;     // byte within the current entry or part
	logic [31:0] acc_q;      // assembled entry or read word

	// read return tracking
	logic        rd_s1;
	logic [1:0]  lane_s1;

	// byte memory
	logic [7:0]               mem [MemBytes];
	logic [7:0]               mem_rdata_q;
	logic [MEM_ADDR_BITS-1:0] mem_addr;
	logic                     mem_re;
	logic                     mem_we;
	logic [1:0]               lane_sel;

	// accept-time decode of the word
	logic [2:0]  n_clamp;
	logic [11:0] off;
	logic [12:0] off_end;
	logic        crossed_in;
	logic [12:0] first_len;
	logic [2:0]  len1_in;

	// walk and check terms
	logic [31:0] va_part;
	logic [31:0] dir_ea;
	logic [31:0] tab_ea;
	logic [31:0] ea;
	logic        ea_ok;
	logic        pa1_ok;
	logic        pa2_ok;
	logic        range_chk;
	logic [2:0]  len_cur;
	logic        last_byte;
	logic [1:0]  data_lane;
	logic [31:0] pa_walk;

	// Clamp the byte count: zero reads as one, five and up as four.
	always_comb begin
		if (byte_count == 3'd0) begin
			n_clamp = 3'd1;
		end else if (byte_count > 3'd4) begin
			n_clamp = 3'd4;
		end else begin
			n_clamp = byte_count;
		end
	end

	// Split where the bytes run past the end of the 4 KiB page.
	assign off        = virtual_address[pvma_pkg::PAGE_BITS-1:0];
	assign off_end    = {1'b0, off} + {10'd0, n_clamp};
	assign crossed_in = off_end > 13'h1000;
	assign first_len  = 13'h1000 - {1'b0, off};
	assign len1_in    = crossed_in ? first_len[2:0] : n_clamp;

	// Entry address of the current walk level; the table level takes its frame
	// from the directory entry held in the accumulator.
	assign va_part = part_q ? va2_q : va_q;
	assign dir_ea  = {directory_frame_q, 12'd0}
		+ {20'd0, va_part[31:pvma_pkg::DIR_SHIFT], 2'b00};
	assign tab_ea  = {acc_q[31:pvma_pkg::PAGE_BITS], 12'd0}
		+ {20'd0, va_part[pvma_pkg::DIR_SHIFT-1:pvma_pkg::PAGE_BITS], 2'b00};
	assign ea      = (lvl_q == pvma_pkg::LVL_TAB) ? tab_ea : dir_ea;
	assign ea_ok   = ({1'b0, ea} + 33'd4) <= MemEnd;
	assign pa_walk = {acc_q[31:pvma_pkg::PAGE_BITS], va_part[pvma_pkg::PAGE_BITS-1:0]};

	// All data bytes of both parts must lie inside memory.
	assign pa1_ok    = ({1'b0, pa1_q} + {30'd0, len1_q}) <= MemEnd;
	assign pa2_ok    = ({1'b0, pa2_q} + {30'd0, len2_q}) <= MemEnd;
	assign range_chk = range_q | ~pa1_ok | (crossed_q & ~pa2_ok);

	// The upper part lands above the lower part's bytes, both in the read word
	// and in the write word, so one lane index serves both directions.
	assign len_cur   = part_q ? len2_q : len1_q;
	assign last_byte = ({1'b0, bcnt_q} + 3'd1) == len_cur;
	assign data_lane = part_q ? (len1_q[1:0] + bcnt_q) : bcnt_q;
	assign lane_sel  = (state_q == pvma_pkg::ST_DATA) ? data_lane : bcnt_q;
	assign mem_addr  = base_q[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(bcnt_q);

	// Next state and memory strobes.
	always_comb begin
		state_d = state_q;
		mem_re  = 1'b0;
		mem_we  = 1'b0;
		unique case (state_q)
			pvma_pkg::ST_IDLE: begin
				if (start) begin
					state_d = paging_enable_q ? pvma_pkg::ST_WALK_ADDR : pvma_pkg::ST_CHECK;
				end
			end
			pvma_pkg::ST_WALK_ADDR: begin
				// an entry beyond memory reads as zero without a fetch
				state_d = ea_ok ? pvma_pkg::ST_ENTRY : pvma_pkg::ST_WALK_NEXT;
			end
			pvma_pkg::ST_ENTRY: begin
				mem_re = 1'b1;
				if (bcnt_q == 2'd3) begin
					state_d = pvma_pkg::ST_ENTRY_WAIT;
				end
			end
			pvma_pkg::ST_ENTRY_WAIT: begin
				state_d = pvma_pkg::ST_WALK_NEXT;
			end
			pvma_pkg::ST_WALK_NEXT: begin
				if (lvl_q == pvma_pkg::LVL_DIR || (!part_q && crossed_q)) begin
					state_d = pvma_pkg::ST_WALK_ADDR;
				end else begin
					state_d = pvma_pkg::ST_CHECK;
				end
			end
			pvma_pkg::ST_CHECK: begin
				state_d = range_chk ? pvma_pkg::ST_DONE : pvma_pkg::ST_DATA;
			end
			pvma_pkg::ST_DATA: begin
				mem_re = (mode_q == pvma_pkg::MODE_READ);
				mem_we = (mode_q == pvma_pkg::MODE_WRITE);
				if (last_byte && (part_q || !crossed_q)) begin
					state_d = pvma_pkg::ST_DATA_WAIT;
				end
			end
			pvma_pkg::ST_DATA_WAIT: begin
				state_d = pvma_pkg::ST_DONE;
			end
			pvma_pkg::ST_DONE: begin
				state_d = pvma_pkg::ST_IDLE;
			end
			default: begin
				state_d = pvma_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pvma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes must arrive only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_enable_q   <= 1'b0;
			directory_frame_q <= '0;
		end else if (config_write) begin
			unique case (config_index)
				pvma_pkg::CFG_PAGING_ENABLE:   paging_enable_q   <= config_data[0];
				pvma_pkg::CFG_DIRECTORY_FRAME: directory_frame_q <= config_data;
				default: ;
			endcase
		end
	end

	// Read return tracking: the byte fetched in one cycle lands in the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane_sel;
	end

	// Byte memory: one port, one access per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= wdata_q[data_lane*8 +: 8];
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_addr];
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		// drop each returning byte into its lane
		if (rd_s1) begin
			acc_q[lane_s1*8 +: 8] <= mem_rdata_q;
		end
		unique case (state_q)
			pvma_pkg::ST_IDLE: begin
				if (start) begin
					// hold the word and set up the lower part's walk
					mode_q    <= mode;
					va_q      <= virtual_address;
					va2_q     <= virtual_address + {29'd0, len1_in};
					wdata_q   <= write_data;
					len1_q    <= len1_in;
					len2_q    <= n_clamp - len1_in;
					crossed_q <= crossed_in;
					range_q   <= 1'b0;
					part_q    <= 1'b0;
					lvl_q     <= pvma_pkg::LVL_DIR;
					// paging off: the physical addresses are the virtual ones
					pa1_q     <= virtual_address;
					pa2_q     <= virtual_address + {29'd0, len1_in};
				end
			end
			pvma_pkg::ST_WALK_ADDR: begin
				base_q <= ea;
				bcnt_q <= 2'd0;
				if (!ea_ok) begin
					// flag the access and walk on from frame zero
					range_q <= 1'b1;
					acc_q   <= '0;
				end
			end
			pvma_pkg::ST_ENTRY: begin
				bcnt_q <= bcnt_q + 2'd1;
			end
			pvma_pkg::ST_ENTRY_WAIT: ;
			pvma_pkg::ST_WALK_NEXT: begin
				if (lvl_q == pvma_pkg::LVL_DIR) begin
					lvl_q <= pvma_pkg::LVL_TAB;
				end else begin
					if (part_q) begin
						pa2_q <= pa_walk;
					end else begin
						pa1_q <= pa_walk;
					end
					// advance to the upper part's walk when the access is split
					lvl_q  <= pvma_pkg::LVL_DIR;
					part_q <= 1'b1;
				end
			end
			pvma_pkg::ST_CHECK: begin
				range_q <= range_chk;
				part_q  <= 1'b0;
				base_q  <= pa1_q;
				bcnt_q  <= 2'd0;
				acc_q   <= '0;
			end
			pvma_pkg::ST_DATA: begin
				if (last_byte) begin
					part_q <= 1'b1;
					base_q <= pa2_q;
					bcnt_q <= 2'd0;
				end else begin
					bcnt_q <= bcnt_q + 2'd1;
				end
			end
			pvma_pkg::ST_DATA_WAIT: ;
			pvma_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	// Results stand on the ports while done is high.
	assign busy             = (state_q != pvma_pkg::ST_IDLE);
	assign done             = (state_q == pvma_pkg::ST_DONE);
	assign read_data        = (mode_q == pvma_pkg::MODE_READ && !range_q) ? acc_q : '0;
	assign physical_address = pa1_q;
	assign page_crossed     = crossed_q;
	assign range_error      = range_q;

endmodule

@@ rtl/pvma_checker.sv @@
// Port-level checker of the paged virtual memory access block and its bind.
`timescale 1ns / 1ps
`include "paged_virtual_memory_access_macros.svh"

module pvma_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               config_write,
	input logic                               config_index,
	input logic [pvma_pkg::CFG_DATA_BITS-1:0] config_data,
	input logic                               start,
	input logic                               busy,
	input logic                               mode,
	input logic [31:0]                        virtual_address,
	input logic [2:0]                         byte_count,
	input logic [31:0]                        write_data,
	input logic                               done,
	input logic [31:0]                        read_data,
	input logic [31:0]                        physical_address,
	input logic                               page_crossed,
	input logic                               range_error
);

	// an accepted word sets busy
	`PVMA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// a result only comes out of a busy block
	`PVMA_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	// one strobe per word, then the block is free again
	`PVMA_ASSERT_NEXT(a_done_release, clk, arst_n, done, !busy && !done)
	// a dropped access reads zero
	`PVMA_ASSERT_IMPL(a_error_zero, clk, arst_n, done && range_error, read_data == 32'd0)

endmodule

bind paged_virtual_memory_access pvma_checker u_pvma_checker (.*);

@@ dv/tb_paged_virtual_memory_access.sv @@
// Self-checking testbench of the paged virtual memory access block.
`timescale 1ns / 1ps

module tb_paged_virtual_memory_access;
	import pvma_pkg::*;

	localparam int MEM_BITS      = MEM_ADDR_BITS_DEF;
	localparam int MEM_SIZE      = 1 << MEM_BITS;
	localparam int PAGE_SIZE     = 1 << PAGE_BITS;
	localparam int FRAME_COUNT   = MEM_SIZE / PAGE_SIZE;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_LIMIT  = 100;
	localparam int PHASE_WORDS   = 50;

	// One expected completion of an access, in the order of the result ports.
	typedef struct packed {
		logic [31:0] rd_data;
		logic [31:0] phys_addr;
		logic        crossed;
		logic        out_of_range;
	} access_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     config_write;
	logic                     config_index;
	logic [CFG_DATA_BITS-1:0] config_data;
	logic                     start;
	logic                     busy;
	logic                     mode;
	logic [31:0]              virtual_address;
	logic [2:0]               byte_count;
	logic [31:0]              write_data;
	logic                     done;
	logic [31:0]              read_data;
	logic [31:0]              physical_address;
	logic                     page_crossed;
	logic                     range_error;

	// Shadow of the block's byte memory and translation registers.
	logic [7:0]          mem_image [0:MEM_SIZE-1];
	logic                paging_on;
	logic [19:0]         dir_frame;
	access_result_t      pending_results [$];
	access_result_t      oldest_result;
	int                  mismatch_count;
	int                  sender_idle_pct;

	paged_virtual_memory_access #(
		.MEM_ADDR_BITS(MEM_BITS)
	) u_dut (
		.clk,
		.arst_n,
		.config_write,
		.config_index,
		.config_data,
		.start,
		.busy,
		.mode,
		.virtual_address,
		.byte_count,
		.write_data,
		.done,
		.read_data,
		.physical_address,
		.page_crossed,
		.range_error
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// True when all n bytes from addr lie inside the byte memory.
	function automatic bit fits(input logic [31:0] addr, input int n);
		return longint'(addr) + longint'(n) <= longint'(MEM_SIZE);
	endfunction

	function automatic logic [31:0] load_bytes(input logic [31:0] addr, input int n);
		logic [31:0] v;
		v = 32'd0;
		for (int i = 0; i < n; i++)
			v[8*i +: 8] = mem_image[addr + 32'(i)];
		return v;
	endfunction

	function automatic void store_bytes(input logic [31:0] addr, input int n,
			input logic [31:0] data);
		for (int i = 0; i < n; i++)
			mem_image[addr + 32'(i)] = data[8*i +: 8];
	endfunction

	// Two-level walk; an entry beyond memory flags a fault and reads as zero,
	// so the walk carries on from frame 0.
	function automatic logic [31:0] walk_page_tables(input logic [31:0] va,
			output bit fault);
		logic [31:0] dir_addr;
		logic [31:0] dir_entry;
		logic [31:0] tab_addr;
		logic [31:0] tab_entry;
		fault = 1'b0;
		if (!paging_on)
			return va;
		dir_addr  = {dir_frame, va[31:22], 2'b00};
		dir_entry = 32'd0;
		if (fits(dir_addr, 4))
			dir_entry = load_bytes(dir_addr, 4);
		else
			fault = 1'b1;
		tab_addr  = {dir_entry[31:12], va[21:12], 2'b00};
		tab_entry = 32'd0;
		if (fits(tab_addr, 4))
			tab_entry = load_bytes(tab_addr, 4);
		else
			fault = 1'b1;
		return {tab_entry[31:12], va[11:0]};
	endfunction

	// Work out the completion of one access and apply its writes to the shadow.
	function automatic access_result_t predict_access(input logic m,
			input logic [31:0] va, input logic [2:0] cnt, input logic [31:0] wd);
		access_result_t r;
		int             n;
		int             len_lo;
		int             len_hi;
		logic [31:0]    pa_lo;
		logic [31:0]    pa_hi;
		bit             crossed;
		bit             fault_lo;
		bit             fault_hi;
		bit             bad;
		// a count of zero acts as one byte, counts above four saturate
		n = (cnt == 3'd0) ? 1 : (cnt > 3'd4) ? 4 : int'(cnt);
		crossed = int'(va[11:0]) + n > PAGE_SIZE;
		len_lo  = crossed ? PAGE_SIZE - int'(va[11:0]) : n;
		len_hi  = n - len_lo;
		pa_lo    = walk_page_tables(va, fault_lo);
		pa_hi    = 32'd0;
		fault_hi = 1'b0;
		// the upper part wraps to virtual address 0 past the top of the space
		if (crossed)
			pa_hi = walk_page_tables(va + 32'(len_lo), fault_hi);
		bad = fault_lo || fault_hi || !fits(pa_lo, len_lo)
			|| (crossed && !fits(pa_hi, len_hi));
		r              = '0;
		r.phys_addr    = pa_lo;
		r.crossed      = crossed;
		r.out_of_range = bad;
		// any range fault drops the whole access
		if (!bad) begin
			if (m == MODE_READ) begin
				r.rd_data = load_bytes(pa_lo, len_lo);
				if (crossed)
					r.rd_data |= load_bytes(pa_hi, len_hi) << (8 * len_lo);
			end else begin
				store_bytes(pa_lo, len_lo, wd);
				if (crossed)
					store_bytes(pa_hi, len_hi, wd >> (8 * len_lo));
			end
		end
		return r;
	endfunction

	// Word shaped like a page table entry: mostly a frame inside memory.
	function automatic logic [31:0] entry_word();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(7) != 0)
			w[31:12] = 20'($urandom_range(FRAME_COUNT - 1));
		return w;
	endfunction

	// ---------------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %h, actual %h",
					$time, name, want, got);
		end
	endtask

	// Take each result on the done strobe and match it to the oldest access.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: unrequested result, expected none, actual %h %h %b %b",
						$time, read_data, physical_address, page_crossed, range_error);
			end else begin
				oldest_result = pending_results.pop_front();
				compare_field("read_data", oldest_result.rd_data, read_data);
				compare_field("physical_address", oldest_result.phys_addr,
					physical_address);
				compare_field("page_crossed", oldest_result.crossed, page_crossed);
				compare_field("range_error", oldest_result.out_of_range, range_error);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	// Present one word and hold it until the block takes it. Start is left high
	// on return so back-to-back words never drop it within one time step.
	task automatic issue_access(input logic m, input logic [31:0] va,
			input logic [2:0] cnt, input logic [31:0] wd);
		int gap;
		gap = 0;
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
			gap = $urandom_range(1, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start           <= 1'b1;
		mode            <= m;
		virtual_address <= va;
		byte_count      <= cnt;
		write_data      <= wd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predict_access(m, va, cnt, wd));
	endtask

	// Drop start and wait until every completion is in and the block is free.
	task automatic wait_for_idle();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	// Write both translation registers back to back while the block is idle.
	task automatic set_translation(input logic pg, input logic [19:0] frame);
		wait_for_idle();
		config_write <= 1'b1;
		config_index <= CFG_PAGING_ENABLE;
		config_data  <= CFG_DATA_BITS'(pg);
		@(posedge clk);
		config_index <= CFG_DIRECTORY_FRAME;
		config_data  <= frame;
		@(posedge clk);
		config_write <= 1'b0;
		paging_on = pg;
		dir_frame = frame;
	endtask

	// Fill the whole memory flat so that no byte is read before it is written.
	// The content looks like page table entries, which keeps later walks mostly
	// inside memory.
	task automatic load_memory_image();
		for (int a = 0; a < MEM_SIZE; a += 4)
			issue_access(MODE_WRITE, 32'(a), 3'd4, entry_word());
	endtask

	// Flat addressing: edges of memory, page splits, wrap and odd byte counts.
	task automatic test_flat_access();
		set_translation(1'b0, 20'hfffff);
		issue_access(MODE_WRITE, 32'h0000_0000, 3'd4, 32'h0000_0000);
		issue_access(MODE_READ,  32'h0000_0000, 3'd4, 32'hffff_ffff);
		issue_access(MODE_WRITE, 32'h0000_fffc, 3'd4, 32'hffff_ffff);
		issue_access(MODE_READ,  32'h0000_fffc, 3'd4, 32'h0000_0000);
		issue_access(MODE_READ,  32'h0000_ffff, 3'd1, 32'h0000_0000);
		// split whose upper part falls off the end of memory
		issue_access(MODE_READ,  32'h0000_fffe, 3'd4, 32'h0000_0000);
		issue_access(MODE_WRITE, 32'h0000_fffd, 3'd4, 32'h1234_5678);
		// splits inside memory, then accesses past its end
		issue_access(MODE_READ,  32'h0000_0ffd, 3'd4, 32'h0000_0000);
		issue_access(MODE_WRITE, 32'h0000_1fff, 3'd2, 32'hdead_a5c3);
		issue_access(MODE_READ,  32'h0000_1fff, 3'd2, 32'h0000_0000);
		issue_access(MODE_READ,  32'h0001_0000, 3'd1, 32'h0000_0000);
		issue_access(MODE_WRITE, 32'h00ff_ffff, 3'd4, 32'h8765_4321);
		// wrap from the top of the address space to zero
		issue_access(MODE_READ,  32'hffff_ffff, 3'd4, 32'h0000_0000);
		// out-of-range byte counts
		issue_access(MODE_READ,  32'h0000_0100, 3'd0, 32'h0000_0000);
		issue_access(MODE_WRITE, 32'h0000_0200, 3'd5, 32'hcafe_f00d);
		issue_access(MODE_READ,  32'h0000_0200, 3'd6, 32'h0000_0000);
		issue_access(MODE_READ,  32'h0000_0ffe, 3'd7, 32'h0000_0000);
	endtask

	// Paged addressing: walks, splits across two translations, directory base
	// at both extremes.
	task automatic test_paged_walk();
		set_translation(1'b1, 20'd2);
		issue_access(MODE_READ,  32'h0000_0000, 3'd4, 32'h0000_0000);
		issue_access(MODE_WRITE, 32'h1234_5678, 3'd4, 32'hffff_ffff);
		issue_access(MODE_READ,  32'h1234_5678, 3'd4, 32'h0000_0000);
		issue_access(MODE_READ,  32'h0040_0ffe, 3'd4, 32'h0000_0000);
		issue_access(MODE_WRITE, 32'h7fff_ffff, 3'd3, 32'h00a5_5a3c);
		issue_access(MODE_READ,  32'hffff_fffe, 3'd4, 32'h0000_0000);
		// directory beyond memory: walk faults and continues from frame 0
		set_translation(1'b1, 20'hfffff);
		issue_access(MODE_READ,  32'h8000_0000, 3'd2, 32'h0000_0000);
		set_translation(1'b1, 20'd0);
		issue_access(MODE_READ,  32'hffc0_0abc, 3'd1, 32'h0000_0000);
	endtask

	// One idling setting: several translation settings, random words in each.
	task automatic run_random_phase(input int idle_pct, input bit top_directory);
		logic        m;
		logic [31:0] va;
		logic [2:0]  cnt;
		logic [31:0] wd;
		sender_idle_pct = idle_pct;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: set_translation(1'b1, 20'd0);
				1: set_translation(1'b1, 20'($urandom_range(1, FRAME_COUNT - 1)));
				2: set_translation(1'b0, 20'($urandom));
				default: set_translation(1'b1, top_directory ? 20'hfffff
					: 20'($urandom_range(FRAME_COUNT - 1)));
			endcase
			repeat (PHASE_WORDS) begin
				m   = 1'($urandom_range(1));
				cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
					: 3'($urandom_range(1, 4));
				va  = $urandom;
				// keep most flat accesses inside memory
				if (!paging_on && $urandom_range(9) < 8)
					va = 32'($urandom_range(MEM_SIZE - 1));
				// bias towards the last bytes of a page to force splits
				if ($urandom_range(3) == 0)
					va[11:0] = 12'($urandom_range(PAGE_SIZE - 3, PAGE_SIZE - 1));
				wd  = ($urandom_range(3) == 0) ? $urandom : entry_word();
				issue_access(m, va, cnt, wd);
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(27, 1'b1);
		run_random_phase(56, 1'b0);
		run_random_phase(0, 1'b0);
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n          <= 1'b0;
		config_write    <= 1'b0;
		config_index    <= CFG_PAGING_ENABLE;
		config_data     <= '0;
		start           <= 1'b0;
		mode            <= MODE_READ;
		virtual_address <= 32'd0;
		byte_count      <= 3'd1;
		write_data      <= 32'd0;
		mismatch_count  = 0;
		sender_idle_pct = 0;
		paging_on       = 1'b0;
		dir_frame       = 20'd0;
		for (int a = 0; a < MEM_SIZE; a++)
			mem_image[a] = 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_memory_image();
		test_flat_access();
		test_paged_walk();
		test_random_traffic();

		wait_for_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
